### design/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, register indexes and clamp helpers for the PID step block.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // default build-time settings
  localparam int unsigned SamplePeriodMsDefault = 15;
  localparam bit          ResetOnCrossDefault   = 1'b0;

  // configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // wide intermediate sums
  localparam int unsigned AccSumW = 34;
  localparam int unsigned DrvSumW = 35;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_BIAS_TERM = 3'd3,
    REG_OUT_UPPER = 3'd4,
    REG_OUT_LOWER = 3'd5,
    REG_ACC_UPPER = 3'd6,
    REG_ACC_LOWER = 3'd7
  } reg_idx_t;

  // configuration register file
  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [15:0] bias_term;
    logic signed [15:0] out_upper;
    logic signed [15:0] out_lower;
    logic signed [31:0] acc_upper;
    logic signed [31:0] acc_lower;
  } cfg_t;

  // limit writes that call for a re-clamp of the held state
  typedef struct packed {
    logic out_lim;
    logic acc_lim;
  } cfg_evt_t;

  // one input item
  typedef struct packed {
    logic signed [15:0] reading;
    logic signed [15:0] setpoint;
    logic [31:0]        now_ms;
    logic               enabled;
  } item_t;

  // controller state carried between items
  typedef struct packed {
    logic signed [31:0] accumulator;
    logic signed [15:0] prev_reading;
    logic signed [16:0] prev_error;
    logic [31:0]        prev_time;
    logic signed [15:0] held_drive;
  } state_t;

  // upper limit tested first, then lower limit
  function automatic logic signed [15:0] clamp_drive(
    input logic signed [DrvSumW-1:0] v,
    input logic signed [15:0]        hi,
    input logic signed [15:0]        lo
  );
    logic signed [15:0] r;
    if (v > DrvSumW'(hi)) begin
      r = hi;
    end else if (v < DrvSumW'(lo)) begin
      r = lo;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_acc(
    input logic signed [AccSumW-1:0] v,
    input logic signed [31:0]        hi,
    input logic signed [31:0]        lo
  );
    logic signed [31:0] r;
    if (v > AccSumW'(hi)) begin
      r = hi;
    end else if (v < AccSumW'(lo)) begin
      r = lo;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/pidc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pidc_cfg_regs
// Gain, bias and limit registers with a flag for each limit write.
// ----------------------------------------------------------------------------
module pidc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pidc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pidc_pkg::CfgDataW-1:0]  cfg_data,
  output pidc_pkg::cfg_t                 cfg,
  output pidc_pkg::cfg_evt_t             evt
);
  import pidc_pkg::*;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p    <= '0;
      cfg.gain_i    <= '0;
      cfg.gain_d    <= '0;
      cfg.bias_term <= '0;
      cfg.out_upper <= 16'sd32767;
      cfg.out_lower <= -16'sd32768;
      cfg.acc_upper <= 32'sd32767;
      cfg.acc_lower <= -32'sd32768;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_P:    cfg.gain_p    <= cfg_data[15:0];
        REG_GAIN_I:    cfg.gain_i    <= cfg_data[15:0];
        REG_GAIN_D:    cfg.gain_d    <= cfg_data[15:0];
        REG_BIAS_TERM: cfg.bias_term <= cfg_data[15:0];
        REG_OUT_UPPER: cfg.out_upper <= cfg_data[15:0];
        REG_OUT_LOWER: cfg.out_lower <= cfg_data[15:0];
        REG_ACC_UPPER: cfg.acc_upper <= cfg_data;
        REG_ACC_LOWER: cfg.acc_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  // one-cycle flags so the state re-clamps against the new limits
  always_ff @(posedge clk) begin
    if (rst) begin
      evt <= '0;
    end else begin
      evt.out_lim <= cfg_we && (reg_idx_t'(cfg_index) == REG_OUT_UPPER ||
                                reg_idx_t'(cfg_index) == REG_OUT_LOWER);
      evt.acc_lim <= cfg_we && (reg_idx_t'(cfg_index) == REG_ACC_UPPER ||
                                reg_idx_t'(cfg_index) == REG_ACC_LOWER);
    end
  end

  // a write to the lower output limit always raises its flag on the next edge
  a_out_evt: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && reg_idx_t'(cfg_index) == REG_OUT_LOWER) |=> evt.out_lim)
    else $error("out limit write did not flag re-clamp");

  a_evt_excl: assert property (@(posedge clk) disable iff (rst)
    !(evt.out_lim && evt.acc_lim))
    else $error("both limit flags raised by one write");

  a_no_evt: assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> !evt.out_lim && !evt.acc_lim)
    else $error("limit flag without a write");

endmodule

### design/pidc_update.sv
// ----------------------------------------------------------------------------
// pidc_update
// One control update: error, integral, derivative on measurement, clamps.
// ----------------------------------------------------------------------------
module pidc_update #(
  parameter int unsigned SAMPLE_PERIOD_MS = pidc_pkg::SamplePeriodMsDefault,
  parameter bit          RESET_ON_CROSS   = pidc_pkg::ResetOnCrossDefault
) (
  input  pidc_pkg::item_t  item,
  input  pidc_pkg::state_t st,
  input  pidc_pkg::cfg_t   cfg,
  output pidc_pkg::state_t st_next,
  output logic             upd
);
  import pidc_pkg::*;

  logic [31:0]          elapsed;
  logic                 due;
  logic signed [16:0]   err;
  logic signed [16:0]   delta;
  logic signed [32:0]   prod_p;
  logic signed [32:0]   prod_i;
  logic signed [32:0]   prod_d;
  logic signed [24:0]   term_p;
  logic signed [24:0]   term_i;
  logic signed [24:0]   term_d;
  logic signed [AccSumW-1:0] acc_sum;
  logic signed [AccSumW-1:0] acc_sel;
  logic signed [31:0]   acc_new;
  logic signed [DrvSumW-1:0] drv_sum;
  logic signed [15:0]   drv_new;
  logic                 crossed;

  // sample period check, modulo 2^32
  assign elapsed = item.now_ms - st.prev_time;
  assign due     = elapsed >= 32'(SAMPLE_PERIOD_MS);

  // error and measurement change
  assign err   = 17'(item.setpoint) - 17'(item.reading);
  assign delta = 17'(item.reading) - 17'(st.prev_reading);

  // three parallel Q8.8 products, floored by dropping the fraction
  assign prod_p = cfg.gain_p * err;
  assign prod_i = cfg.gain_i * err;
  assign prod_d = cfg.gain_d * delta;
  assign term_p = prod_p[32:8];
  assign term_i = prod_i[32:8];
  assign term_d = prod_d[32:8];

  // integral with optional reset on sign change, then clamp
  assign crossed = RESET_ON_CROSS && (err[16] != st.prev_error[16]);
  assign acc_sum = AccSumW'(st.accumulator) + AccSumW'(term_i);
  assign acc_sel = crossed ? '0 : acc_sum;
  assign acc_new = clamp_acc(acc_sel, cfg.acc_upper, cfg.acc_lower);

  // drive sum and clamp
  assign drv_sum = DrvSumW'(term_p) + DrvSumW'(acc_new) - DrvSumW'(term_d)
                 + DrvSumW'(cfg.bias_term);
  assign drv_new = clamp_drive(drv_sum, cfg.out_upper, cfg.out_lower);

  // next state selection
  always_comb begin
    st_next = st;
    upd     = 1'b0;
    if (!item.enabled) begin
      st_next.held_drive = '0;
    end else if (due) begin
      st_next.accumulator  = acc_new;
      st_next.prev_reading = item.reading;
      st_next.prev_error   = err;
      st_next.prev_time    = item.now_ms;
      st_next.held_drive   = drv_new;
      upd                  = 1'b1;
    end
  end

endmodule

### design/pidc_state.sv
// ----------------------------------------------------------------------------
// pidc_state
// Controller state registers, updated per item or re-clamped on limit writes.
// ----------------------------------------------------------------------------
module pidc_state (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               enabled,
  input  pidc_pkg::state_t   st_next,
  input  pidc_pkg::cfg_t     cfg,
  input  pidc_pkg::cfg_evt_t evt,
  output pidc_pkg::state_t   st
);
  import pidc_pkg::*;

  // item update wins; limit re-clamps happen only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end else begin
      if (evt.out_lim) begin
        st.held_drive <= clamp_drive(DrvSumW'(st.held_drive),
                                     cfg.out_upper, cfg.out_lower);
      end
      if (evt.acc_lim) begin
        st.accumulator <= clamp_acc(AccSumW'(st.accumulator),
                                    cfg.acc_upper, cfg.acc_lower);
      end
    end
  end

  // a disabled item leaves a zero held drive
  a_disable_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && !enabled) |=> st.held_drive == '0)
    else $error("held drive not cleared by disabled item");

  // timestamp only moves with an item
  a_time_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(st.prev_time))
    else $error("prev_time changed without an item");

  // a disabled item leaves the integral alone
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (adv && !enabled) |=> $stable(st.accumulator))
    else $error("accumulator changed on disabled item");

endmodule

### design/pid_controller_step.sv
// ----------------------------------------------------------------------------
// pid_controller_step
// Fixed-point PID controller, derivative on measurement, one item per cycle unless the result side stalls.
// ----------------------------------------------------------------------------
// Path: an accepted item is loaded into the input register, then into the
//   result register once the result slot is free.
// Throughput: 1 item per cycle while the result side accepts; the accumulator
//   loop closes through the combinational multiply, add and clamp path.
// Reset: synchronous rst clears the state, loads the register reset values
//   and empties both the input and result registers.
module pid_controller_step #(
  parameter int unsigned SAMPLE_PERIOD_MS = pidc_pkg::SamplePeriodMsDefault,
  parameter bit          RESET_ON_CROSS   = pidc_pkg::ResetOnCrossDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [pidc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pidc_pkg::CfgDataW-1:0] cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            reading,
  input  logic signed [15:0]            setpoint,
  input  logic [31:0]                   now_ms,
  input  logic                          enabled,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            drive,
  output logic                          updated
);
  import pidc_pkg::*;

  cfg_t     cfg;
  cfg_evt_t evt;
  state_t   st;
  state_t   st_next;
  logic     upd;
  item_t    stage;
  logic     stage_valid;
  logic     adv;

  // handshake: the input register moves on when the result slot frees
  assign adv      = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.reading  <= reading;
      stage.setpoint <= setpoint;
      stage.now_ms   <= now_ms;
      stage.enabled  <= enabled;
    end
  end

  pidc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .evt       (evt)
  );

  pidc_update #(
    .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS),
    .RESET_ON_CROSS   (RESET_ON_CROSS)
  ) u_update (
    .item    (stage),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .upd     (upd)
  );

  pidc_state u_state (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .enabled (stage.enabled),
    .st_next (st_next),
    .cfg     (cfg),
    .evt     (evt),
    .st      (st)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive   <= st_next.held_drive;
      updated <= upd;
    end
  end

  // a processed item always lands in the result register
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("processed item missing from result register");

  // a stalled stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !adv) |=> stage_valid)
    else $error("stalled item lost from input register");

  // no new item while both registers are full and the output is stalled
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted while pipeline is full");

  // the result matches the state left by its item
  a_drive_state: assert property (@(posedge clk) disable iff (rst)
    adv |=> drive == st.held_drive)
    else $error("result differs from held drive");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PID step block: directed cases for startup,
// gain extremes, crossed limits, limit re-clamps and error sign changes,
// then randomized tuning phases. A predictor tracks the controller state and
// every result item is compared against it while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pidc_pkg::*;

  localparam int unsigned PERIOD_MS   = 15;
  localparam bit          CROSS_RESET = 1'b0;

  typedef enum {TUNE_MILD, TUNE_WILD, TUNE_CROSSED, TUNE_EDGE} tune_style_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               updated;
  } pid_result_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic signed [15:0]   reading   = '0;
  logic signed [15:0]   setpoint  = '0;
  logic [31:0]          now_ms    = '0;
  logic                 enabled   = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [15:0]   drive;
  logic                 updated;

  // predicted register file
  logic signed [15:0]   p_gain, i_gain, d_gain, bias_val, drv_hi, drv_lo;
  logic signed [31:0]   acc_hi, acc_lo;
  // predicted controller state
  logic signed [31:0]   acc_q;
  logic signed [15:0]   last_rd;
  logic signed [16:0]   last_err;
  logic [31:0]          last_ms;
  logic signed [15:0]   held_q;

  pid_result_t          expected_q[$];
  int unsigned          fail_count = 0;
  int unsigned          tx_calm    = 0;
  int unsigned          rx_hold    = 0;
  int unsigned          rx_calm    = 0;
  logic signed [15:0]   target_val = '0;

  pid_controller_step #(
    .SAMPLE_PERIOD_MS(PERIOD_MS),
    .RESET_ON_CROSS  (CROSS_RESET)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .reading  (reading),
    .setpoint (setpoint),
    .now_ms   (now_ms),
    .enabled  (enabled),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive    (drive),
    .updated  (updated)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // upper limit wins when the pair is crossed
  function automatic longint clamp_range(input longint v, input longint hi, input longint lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] due_ms(input logic [31:0] delta);
    return last_ms + delta;
  endfunction

  task automatic model_reset();
    p_gain   = '0;
    i_gain   = '0;
    d_gain   = '0;
    bias_val = '0;
    drv_hi   = 16'sh7FFF;
    drv_lo   = 16'sh8000;
    acc_hi   = 32'sd32767;
    acc_lo   = -32'sd32768;
    acc_q    = '0;
    last_rd  = '0;
    last_err = '0;
    last_ms  = '0;
    held_q   = '0;
  endtask

  // controller update for one accepted item, queues the expected result
  task automatic predict_drive(input logic signed [15:0] rd, input logic signed [15:0] sp,
                               input logic [31:0] t, input logic en);
    longint      err;
    longint      acc;
    longint      drv;
    logic [31:0] since;
    pid_result_t r;
    r.updated = 1'b0;
    since = t - last_ms;
    if (!en) begin
      held_q = '0;
    end else if (since >= PERIOD_MS) begin
      err = longint'(sp) - longint'(rd);
      acc = longint'(acc_q) + ((longint'(i_gain) * err) >>> 8);
      if (CROSS_RESET && ((err < 0) != (last_err < 0))) begin
        acc = 0;
      end
      acc = clamp_range(acc, acc_hi, acc_lo);
      drv = ((longint'(p_gain) * err) >>> 8) + acc
          - ((longint'(d_gain) * (longint'(rd) - longint'(last_rd))) >>> 8)
          + longint'(bias_val);
      drv = clamp_range(drv, drv_hi, drv_lo);
      acc_q     = acc[31:0];
      held_q    = drv[15:0];
      last_rd   = rd;
      last_err  = err[16:0];
      last_ms   = t;
      r.updated = 1'b1;
    end
    r.drive = held_q;
    expected_q.push_back(r);
  endtask

  // register write; the predicted registers and state follow it
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P:    p_gain = data[15:0];
      REG_GAIN_I:    i_gain = data[15:0];
      REG_GAIN_D:    d_gain = data[15:0];
      REG_BIAS_TERM: bias_val = data[15:0];
      REG_OUT_UPPER: begin
        drv_hi = data[15:0];
        held_q = 16'(clamp_range(held_q, drv_hi, drv_lo));
      end
      REG_OUT_LOWER: begin
        drv_lo = data[15:0];
        held_q = 16'(clamp_range(held_q, drv_hi, drv_lo));
      end
      REG_ACC_UPPER: begin
        acc_hi = data;
        acc_q  = 32'(clamp_range(acc_q, acc_hi, acc_lo));
      end
      REG_ACC_LOWER: begin
        acc_lo = data;
        acc_q  = 32'(clamp_range(acc_q, acc_hi, acc_lo));
      end
    endcase
    @(posedge clk);
  endtask

  // send one item; valid stays high on return so back-to-back items need no toggle
  task automatic send_item(input logic signed [15:0] rd, input logic signed [15:0] sp,
                           input logic [31:0] t, input logic en);
    int unsigned gap;
    if (tx_calm != 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    reading  <= rd;
    setpoint <= sp;
    now_ms   <= t;
    enabled  <= en;
    do @(posedge clk); while (!in_ready);
    predict_drive(rd, sp, t, en);
  endtask

  // drain all pending results, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // reset register values, early timestamps, disabled item
  task automatic test_startup();
    send_item(16'sd0, 16'sd0, 32'd0, 1'b1);
    send_item(16'sh7FFF, 16'sh8000, 32'd14, 1'b1);
    send_item(16'sh7FFF, 16'sh8000, 32'd15, 1'b1);
    send_item(16'sh8000, 16'sh7FFF, 32'd100, 1'b0);
  endtask

  // largest gains and errors, timestamp wrap
  task automatic test_gain_extremes();
    settle();
    write_reg(REG_GAIN_P, 32'h0000_7FFF);
    write_reg(REG_GAIN_I, 32'h0000_8000);
    write_reg(REG_GAIN_D, 32'h0000_8000);
    write_reg(REG_BIAS_TERM, 32'h0000_7FFF);
    write_reg(REG_ACC_UPPER, 32'h7FFF_FFFF);
    write_reg(REG_ACC_LOWER, 32'h8000_0000);
    send_item(16'sh8000, 16'sh7FFF, 32'd200, 1'b1);
    send_item(16'sh7FFF, 16'sh8000, 32'd215, 1'b1);
    send_item(16'sd0, 16'sd0, 32'hFFFF_FFF0, 1'b1);
    send_item(16'sd100, -16'sd100, 32'h0000_0005, 1'b1);
    send_item(16'sd5, 16'sd5, 32'h0000_0010, 1'b1);
    settle();
    write_reg(REG_GAIN_P, 32'h0000_8000);
    write_reg(REG_GAIN_I, 32'h0000_7FFF);
    write_reg(REG_GAIN_D, 32'h0000_7FFF);
    write_reg(REG_BIAS_TERM, 32'h0000_8000);
    send_item(16'sh8000, 16'sh7FFF, 32'h0000_0040, 1'b1);
    send_item(16'sh7FFF, 16'sh8000, 32'h0000_0080, 1'b1);
    send_item(16'sd0, 16'sd0, 32'h0000_0080, 1'b1);
  endtask

  // lower limit above upper limit on both clamps
  task automatic test_crossed_limits();
    settle();
    write_reg(REG_GAIN_P, 32'h0000_0100);
    write_reg(REG_GAIN_I, 32'h0000_0100);
    write_reg(REG_GAIN_D, 32'h0000_0000);
    write_reg(REG_BIAS_TERM, 32'h0000_0000);
    write_reg(REG_OUT_UPPER, 32'h0000_FF9C);
    write_reg(REG_OUT_LOWER, 32'h0000_0064);
    write_reg(REG_ACC_UPPER, 32'hFFFF_FFFB);
    write_reg(REG_ACC_LOWER, 32'h0000_0005);
    send_item(16'sd0, 16'sd1000, due_ms(20), 1'b1);
    send_item(16'sd0, -16'sd1000, due_ms(20), 1'b1);
    send_item(16'sd0, 16'sd0, due_ms(20), 1'b1);
  endtask

  // limit writes re-clamp the held drive and the accumulator
  task automatic test_limit_reclamp();
    settle();
    write_reg(REG_OUT_UPPER, 32'h0000_7FFF);
    write_reg(REG_OUT_LOWER, 32'h0000_8000);
    write_reg(REG_ACC_UPPER, 32'd1_000_000);
    write_reg(REG_ACC_LOWER, -32'sd1_000_000);
    write_reg(REG_GAIN_P, 32'h0000_0000);
    write_reg(REG_GAIN_I, 32'h0000_7FFF);
    send_item(16'sd0, 16'sd20000, due_ms(20), 1'b1);
    settle();
    write_reg(REG_OUT_UPPER, 32'd1000);
    write_reg(REG_OUT_LOWER, 32'h0000_F830);
    send_item(16'sd0, 16'sd0, due_ms(1), 1'b1);
    settle();
    write_reg(REG_ACC_UPPER, 32'd300);
    write_reg(REG_GAIN_I, 32'h0000_0000);
    send_item(16'sd0, 16'sd0, due_ms(20), 1'b1);
    settle();
    write_reg(REG_OUT_LOWER, 32'd2000);
    send_item(16'sd0, 16'sd0, due_ms(2), 1'b1);
    settle();
    write_reg(REG_OUT_LOWER, 32'h0000_8000);
    write_reg(REG_ACC_LOWER, 32'd500);
    send_item(16'sd0, 16'sd0, due_ms(20), 1'b1);
  endtask

  // error goes positive, negative, zero, positive
  task automatic test_sign_change();
    settle();
    write_reg(REG_OUT_UPPER, 32'h0000_7FFF);
    write_reg(REG_ACC_UPPER, 32'd100_000);
    write_reg(REG_ACC_LOWER, -32'sd100_000);
    write_reg(REG_GAIN_I, 32'h0000_0100);
    write_reg(REG_GAIN_D, 32'h0000_0080);
    send_item(16'sd0, 16'sd50, due_ms(20), 1'b1);
    send_item(16'sd0, -16'sd30, due_ms(20), 1'b1);
    send_item(16'sd7, 16'sd7, due_ms(20), 1'b1);
    send_item(16'sd0, 16'sd10, due_ms(20), 1'b1);
  endtask

  // write all registers for one tuning style, starting at a random index
  task automatic tune(input tune_style_t style);
    logic [31:0] vals [8];
    int unsigned first;
    for (int k = 0; k < 4; k++) begin
      vals[k] = $urandom_range(0, 2047) - 1024;
    end
    vals[4] = $urandom_range(0, 32767);
    vals[5] = 32'h0 - $urandom_range(0, 32768);
    vals[6] = $urandom_range(1000, 200_000);
    vals[7] = 32'h0 - $urandom_range(1000, 200_000);
    case (style)
      TUNE_WILD: begin
        for (int k = 0; k < 8; k++) vals[k] = $urandom;
      end
      TUNE_CROSSED: begin
        vals[4] = 32'h0 - $urandom_range(0, 1000);
        vals[5] = $urandom_range(1, 1000);
        vals[6] = 32'h0 - $urandom_range(0, 50_000);
        vals[7] = $urandom_range(1, 50_000);
      end
      TUNE_EDGE: begin
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 3))
            0: vals[k] = 32'h0000_7FFF;
            1: vals[k] = 32'h0000_8000;
            2: vals[k] = 32'h0000_0000;
            default: vals[k] = 32'h0000_0001;
          endcase
        end
        vals[4] = 32'h0000_7FFF;
        vals[5] = 32'h0000_8000;
        if ($urandom_range(0, 1) == 0) begin
          vals[6] = 32'h7FFF_FFFF;
          vals[7] = 32'h8000_0000;
        end else begin
          vals[6] = 32'd32767;
          vals[7] = 32'hFFFF_8000;
        end
      end
      default: ;
    endcase
    first = $urandom_range(0, 7);
    for (int k = 0; k < 8; k++) begin
      write_reg(reg_idx_t'((k + first) % 8), vals[(k + first) % 8]);
    end
  endtask

  // one random item: mostly due updates near the target, some early, disabled or noise
  task automatic send_random_reading();
    logic signed [15:0] rd;
    logic signed [15:0] sp;
    logic [31:0]        t;
    logic               en;
    int unsigned        pick;
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0) target_val = 16'($urandom);
      else target_val = 16'($urandom_range(0, 4000) - 2000);
    end
    sp = target_val;
    if ($urandom_range(0, 3) == 0) rd = 16'($urandom);
    else rd = 16'(target_val + ($urandom_range(0, 1600) - 800));
    en = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      en = 1'b0;
      t  = $urandom;
      rd = 16'($urandom);
      sp = 16'($urandom);
    end else if (pick < 15) begin
      t = $urandom;
    end else if (pick < 27) begin
      t = last_ms + $urandom_range(0, PERIOD_MS - 1);
    end else if (pick < 32) begin
      t = last_ms + $urandom;
    end else begin
      t = last_ms + PERIOD_MS + $urandom_range(0, 40);
    end
    send_item(rd, sp, t, en);
  endtask

  task automatic test_random_phase(input tune_style_t style, input int unsigned count);
    settle();
    tune(style);
    repeat (count) send_random_reading();
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_calm != 0) begin
        rx_calm--;
      end else if ($urandom_range(0, 99) < 30) begin
        rx_hold = idle_len();
      end else if ($urandom_range(0, 99) < 2) begin
        rx_calm = $urandom_range(20, 80);
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin : check_results
    pid_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result item with none pending: drive %0d updated %0b", drive, updated);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (drive !== want.drive) begin
          $error("drive mismatch: expected %0d, actual %0d", want.drive, drive);
          fail_count++;
        end
        if (updated !== want.updated) begin
          $error("updated mismatch: expected %0b, actual %0b", want.updated, updated);
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin : main_seq
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    model_reset();
    @(posedge clk);
    test_startup();
    test_gain_extremes();
    test_crossed_limits();
    test_limit_reclamp();
    test_sign_change();
    test_random_phase(TUNE_MILD, 150);
    test_random_phase(TUNE_WILD, 150);
    test_random_phase(TUNE_CROSSED, 100);
    test_random_phase(TUNE_EDGE, 150);
    test_random_phase(TUNE_MILD, 150);
    test_random_phase(TUNE_WILD, 200);
    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
